### sv/sps_pkg.sv
// shared types, codes and coil tables of the stepper phase sequencer
package sps_pkg;

  // input opcodes
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_MOVE   = 2'd1;
  localparam logic [1:0] OP_ROTATE = 2'd2;

  // wiring modes
  localparam logic [1:0] MODE_DETACHED = 2'd0;
  localparam logic [1:0] MODE_FOUR     = 2'd1;
  localparam logic [1:0] MODE_FIVE     = 2'd2;
  localparam logic [1:0] MODE_UNUSED   = 2'd3;  // behaves as detached

  // register indexes
  localparam logic REG_WIRING = 1'b0;
  localparam logic REG_PERIOD = 1'b1;

  // motor status codes
  localparam logic [1:0] STATUS_IDLE   = 2'd0;
  localparam logic [1:0] STATUS_MOVE   = 2'd1;
  localparam logic [1:0] STATUS_ROTATE = 2'd2;

  // direction sign, two bit signed
  localparam logic [1:0] DIR_STOP = 2'b00;
  localparam logic [1:0] DIR_FWD  = 2'b01;
  localparam logic [1:0] DIR_REV  = 2'b11;

  localparam logic [31:0] PERIOD_AT_ATTACH = 32'd1_000_000;
  localparam logic [3:0]  PHASES_FOUR      = 4'd4;
  localparam logic [3:0]  PHASES_FIVE      = 4'd10;
  localparam logic [3:0]  PHASE_LAST_FOUR  = PHASES_FOUR - 4'd1;
  localparam logic [3:0]  PHASE_LAST_FIVE  = PHASES_FIVE - 4'd1;

  typedef struct packed {
    logic        valid;
    logic        index;
    logic [31:0] data;
  } cfg_wr_t;

  // packed lowest field last: coils sits in the low bits
  typedef struct packed {
    logic        stepped;
    logic [1:0]  run_direction;
    logic [31:0] steps_left;
    logic [1:0]  motor_status;
    logic [4:0]  coils;
  } result_t;

  function automatic logic [4:0] coil_four(input logic [1:0] phase);
    logic [4:0] pat;
    case (phase)
      2'd0:    pat = 5'd5;
      2'd1:    pat = 5'd6;
      2'd2:    pat = 5'd10;
      default: pat = 5'd9;
    endcase
    return pat;
  endfunction

  function automatic logic [4:0] coil_five(input logic [3:0] phase);
    logic [4:0] pat;
    case (phase)
      4'd0:    pat = 5'd22;
      4'd1:    pat = 5'd18;
      4'd2:    pat = 5'd26;
      4'd3:    pat = 5'd10;
      4'd4:    pat = 5'd11;
      4'd5:    pat = 5'd9;
      4'd6:    pat = 5'd13;
      4'd7:    pat = 5'd5;
      4'd8:    pat = 5'd21;
      4'd9:    pat = 5'd20;
      default: pat = 5'd0;
    endcase
    return pat;
  endfunction

endpackage

### sv/sps_core.sv
// motor state, configuration registers and the per-transaction update
module sps_core import sps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_wr_t     cfg_i,
  input  logic        item_valid_i,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] step_count_i,
  input  logic [7:0]  rotate_dir_i,
  output result_t     result_o,
  output logic [1:0]  wiring_mode_o,
  output logic [31:0] step_period_o
);

  logic [1:0]  mode_q;
  logic [31:0] period_q;
  logic [3:0]  phase_q, phase_d;
  logic [1:0]  dir_q, dir_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] elapsed_q, elapsed_d;
  logic [4:0]  coil_q, coil_d;

  logic        attached;
  logic [3:0]  phase_last;
  logic [32:0] elapsed_inc;
  logic        stepped;
  logic [1:0]  status;

  assign attached   = (mode_q == MODE_FOUR) || (mode_q == MODE_FIVE);
  assign phase_last = (mode_q == MODE_FOUR) ? PHASE_LAST_FOUR : PHASE_LAST_FIVE;
  // one bit wider so a count at the top of the range still compares
  assign elapsed_inc = {1'b0, elapsed_q} + 33'd1;

  always_comb begin
    phase_d   = phase_q;
    dir_d     = dir_q;
    rem_d     = rem_q;
    elapsed_d = elapsed_q;
    coil_d    = coil_q;
    stepped   = 1'b0;
    case (opcode_i)
      OP_TICK: begin
        if (attached) begin
          if (elapsed_inc >= {1'b0, period_q}) begin
            elapsed_d = '0;
            stepped   = 1'b1;
            if (dir_q == DIR_FWD) begin
              phase_d = (phase_q == phase_last) ? 4'd0 : phase_q + 4'd1;
            end else if (dir_q == DIR_REV) begin
              phase_d = (phase_q == 4'd0) ? phase_last : phase_q - 4'd1;
            end
            coil_d = (mode_q == MODE_FOUR) ? coil_four(phase_d[1:0]) : coil_five(phase_d);
            if (dir_q != DIR_STOP && rem_q != '0) begin
              rem_d = rem_q - 32'd1;
              if (rem_q == 32'd1) dir_d = DIR_STOP;
            end
          end else begin
            elapsed_d = elapsed_inc[31:0];
          end
        end
      end
      OP_MOVE: begin
        if (step_count_i[31]) begin
          rem_d = 32'd0 - step_count_i;
          dir_d = DIR_REV;
        end else begin
          rem_d = step_count_i;
          dir_d = DIR_FWD;
        end
      end
      OP_ROTATE: begin
        rem_d = '0;
        if (rotate_dir_i == '0) dir_d = DIR_STOP;
        else if (rotate_dir_i[7]) dir_d = DIR_REV;
        else dir_d = DIR_FWD;
      end
      default: ;
    endcase
  end

  always_comb begin
    status = STATUS_IDLE;
    if (attached) begin
      if (rem_d != '0) status = STATUS_MOVE;
      else if (dir_d != DIR_STOP) status = STATUS_ROTATE;
    end
  end

  assign result_o.coils         = attached ? coil_d : 5'd0;
  assign result_o.motor_status  = status;
  assign result_o.steps_left    = rem_d;
  assign result_o.run_direction = dir_d;
  assign result_o.stepped       = stepped;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_DETACHED;
      period_q  <= PERIOD_AT_ATTACH;
      phase_q   <= '0;
      dir_q     <= DIR_STOP;
      rem_q     <= '0;
      elapsed_q <= '0;
      coil_q    <= '0;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == REG_WIRING) begin
        // mode three counts as detached
        mode_q    <= (cfg_i.data[1:0] == MODE_UNUSED) ? MODE_DETACHED : cfg_i.data[1:0];
        period_q  <= PERIOD_AT_ATTACH;
        phase_q   <= '0;
        dir_q     <= DIR_STOP;
        rem_q     <= '0;
        elapsed_q <= '0;
        coil_q    <= '0;
      end else if (cfg_i.data == '0) begin
        // zero period stops the motor and keeps the old period
        dir_q <= DIR_STOP;
        rem_q <= '0;
      end else begin
        period_q <= cfg_i.data;
      end
    end else if (item_valid_i) begin
      phase_q   <= phase_d;
      dir_q     <= dir_d;
      rem_q     <= rem_d;
      elapsed_q <= elapsed_d;
      coil_q    <= coil_d;
    end
  end

  assign wiring_mode_o = mode_q;
  assign step_period_o = period_q;

endmodule

### sv/stepper_phase_sequencer.sv
// top level: stream channels, register port and output buffering
//
// Stepper phase sequencer for one motor.
// Input stream: one transaction per command. tuser carries the opcode
// (tick of one microsecond, counted move, rotate/stop); tdata carries the
// signed step count and the signed rotate direction.
// Output stream: exactly one transaction per input transaction, holding
// the coil pattern, motor status, remaining steps, direction and a flag
// for a phase step taken on this tick.
// Results are registered; throughput is one transaction per cycle while
// s_axis_tready is high, set by the combinational state update.
// A two-entry output buffer (result register plus skid register) lets
// one more transaction in while the receiver stalls; s_axis_tready
// drops only once both entries are full.
// Registers over the APB port: wiring mode at 0x0, step period at 0x4.
// Writing the wiring mode clears the motor state and restores the
// period of 1000000 ticks.
// After reset the motor is detached, coils are off and the period is
// 1000000; no clearing pass is needed.
module stepper_phase_sequencer import sps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // step_count[31:0], rotate_dir[39:32]
  input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // coils[4:0], motor_status[6:5], steps_left[38:7], run_direction[40:39],
  // stepped[41], zeros[47:42]
  output logic [47:0] m_axis_tdata,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_wr_t     cfg;
  result_t     res;
  logic [1:0]  wiring_mode;
  logic [31:0] step_period;
  logic        accept, pop;

  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;

  assign pready     = 1'b1;
  assign cfg.valid  = psel && penable && pwrite && pready;
  assign cfg.index  = paddr[2];
  assign cfg.data   = pwdata;
  assign prdata     = (paddr[2] == REG_PERIOD) ? step_period : {30'd0, wiring_mode};

  assign s_axis_tready = !skid_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pop           = out_valid_q && m_axis_tready;

  sps_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .item_valid_i  (accept),
    .opcode_i      (s_axis_tuser),
    .step_count_i  (s_axis_tdata[31:0]),
    .rotate_dir_i  (s_axis_tdata[39:32]),
    .result_o      (res),
    .wiring_mode_o (wiring_mode),
    .step_period_o (step_period)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) skid_valid_q <= 1'b0;
      else out_valid_q <= accept;
    end else if (!out_valid_q) begin
      out_valid_q <= accept;
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) out_q <= skid_q;
      else if (accept) out_q <= res;
    end else if (!out_valid_q) begin
      if (accept) out_q <= res;
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q};

endmodule

### sv/sps_checker.sv
// port-level checks of the stepper phase sequencer, bound to the top level
module sps_checker import sps_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  result_t r;
  assign r = m_axis_tdata[41:0];

  // a stalled result must hold
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  // counted move shows steps left, rotation shows none
  a_status_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && r.motor_status == STATUS_MOVE |-> r.steps_left != '0)
    else $error("move status without steps left");

  a_rotate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && r.motor_status == STATUS_ROTATE |->
      r.steps_left == '0 && r.run_direction != DIR_STOP)
    else $error("rotate status inconsistent");

  // a step only happens while attached, and every table pattern drives a coil
  a_step_coils: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && r.stepped |-> r.coils != '0)
    else $error("step taken with coils off");

endmodule

bind stepper_phase_sequencer sps_checker u_sps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
